FILE: rtl/wam_pkg.sv
// wam_pkg: shared types, field widths and register reset values for the
// weekly alarm matcher; no dependencies
`timescale 1ns / 1ps

package wam_pkg;

    localparam int ALARM_COUNT_DEF = 4;   // alarms that can fire
    localparam int REG_COUNT       = 4;   // alarm registers on the config port
    localparam int REG_IDX_W       = 2;
    localparam int REG_W           = 19;
    localparam int ADDR_W          = 4;
    localparam int PDATA_W         = 32;
    localparam int DAYS_PER_WEEK   = 7;

    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int WDAY_W  = 3;
    localparam int DAY_W   = 5;
    localparam int OP_W    = 2;
    localparam int IDX_W   = 2;

    // alarm register layout
    localparam int EN_BIT   = 0;
    localparam int MASK_LSB = 1;
    localparam int MIN_LSB  = 8;
    localparam int HOUR_LSB = 14;

    localparam int S_TDATA_W = 24;   // 21 payload bits rounded to bytes
    localparam int M_TDATA_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_CHECK = 2'd0,
        OP_ACK   = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef logic [REG_W-1:0] alarm_word_t;

    // one request, as held in the input stage
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  alarm_index;
        logic [DAY_W-1:0]  day_of_month;
        logic [WDAY_W-1:0] weekday;
        logic [MIN_W-1:0]  minute;
        logic [HOUR_W-1:0] hour;
    } req_t;

    localparam alarm_word_t ALARM_RESET [REG_COUNT] = '{
        19'd122368, 19'd138752, 19'd155136, 19'd171520
    };

endpackage

FILE: rtl/weekly_alarm_matcher.sv
// weekly_alarm_matcher: top level, alarm registers, fired flags and matcher
// depends on wam_pkg
`timescale 1ns / 1ps
//
//  channel   | direction | fields (lsb first)                                   | handshake
//  s_*       | in        | tdata: hour, minute, weekday, day_of_month,           | tvalid/tready
//            |           |        alarm_index, zero pad; tuser: op               |
//  m_*       | out       | tdata: fired_index, zero pad; tuser: fired            | tvalid/tready
//  apb       | in        | alarm registers 0..3 at byte addresses 0,4,8,12       | psel/penable
//
//  one transaction per cycle sustained while m_tready is held high; a request is held
//  in the input register and the match is resolved from it into the result register
//  aresetn is synchronous, active low; clears both stage valids, the fired flags,
//  the known day and restores the alarm registers to their reset words
//  a stall on m_tready holds the result; the input register still takes one more
//  transaction, then s_tready drops until the result moves on

module weekly_alarm_matcher #(
    parameter int ALARM_COUNT = wam_pkg::ALARM_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wam_pkg::S_TDATA_W-1:0] s_tdata,   // hour, minute, weekday, day_of_month, alarm_index
    input  logic [wam_pkg::OP_W-1:0]      s_tuser,   // op
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wam_pkg::M_TDATA_W-1:0] m_tdata,   // fired_index
    output logic                          m_tuser,   // fired
    // config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wam_pkg::ADDR_W-1:0]    paddr,
    input  logic [wam_pkg::PDATA_W-1:0]   pwdata,
    output logic [wam_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import wam_pkg::*;

    // alarm registers
    alarm_word_t alarm_reg [REG_COUNT];

    // input stage
    logic in_valid_reg, in_valid_next;
    req_t in_item_reg;

    // result stage
    logic             out_valid_reg, out_valid_next;
    logic             fired_reg;
    logic [IDX_W-1:0] fired_idx_reg;

    // block state
    logic [ALARM_COUNT-1:0] fired_flags_reg, fired_flags_next;
    logic [DAY_W-1:0]       last_day_reg, last_day_next;

    logic advance;
    logic cfg_we;
    logic [REG_IDX_W-1:0] cfg_idx;

    // match datapath
    logic                   day_change;
    logic [ALARM_COUNT-1:0] flags_base;
    logic [ALARM_COUNT-1:0] hit;
    logic                   hit_any;
    logic [IDX_W-1:0]       hit_idx;

    // ---------------- handshakes ----------------
    // the input stage moves on whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign prdata  = {{(PDATA_W-REG_W){1'b0}}, alarm_reg[cfg_idx]};

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------- match logic ----------------
    // a new known day wipes the flags before the match if a day was known; day 0 means unknown
    assign day_change = (op_t'(in_item_reg.op) == OP_CHECK) &&
                        (in_item_reg.day_of_month != '0) &&
                        (in_item_reg.day_of_month != last_day_reg);
    assign flags_base = (day_change && (last_day_reg != '0)) ? '0 : fired_flags_reg;

    always_comb begin
        logic [DAYS_PER_WEEK-1:0] mask;
        logic                     due;
        for (int i = 0; i < ALARM_COUNT; i++) begin
            mask = alarm_reg[i][MASK_LSB +: DAYS_PER_WEEK];
            // empty mask repeats daily; weekday 0 matches no repeat day
            due  = (mask == '0) ||
                   ((in_item_reg.weekday != '0) && mask[in_item_reg.weekday - 3'd1]);
            hit[i] = alarm_reg[i][EN_BIT] && !flags_base[i] && due &&
                     (alarm_reg[i][HOUR_LSB +: HOUR_W] == in_item_reg.hour) &&
                     (alarm_reg[i][MIN_LSB +: MIN_W] == in_item_reg.minute);
        end
    end

    // lowest matching alarm wins
    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = ALARM_COUNT - 1; i >= 0; i--) begin
            if (hit[i]) begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    // ---------------- state update ----------------
    always_comb begin
        fired_flags_next = fired_flags_reg;
        last_day_next    = last_day_reg;
        if (advance) begin
            case (in_item_reg.op)
                OP_CHECK: begin
                    fired_flags_next = flags_base;
                    if (day_change) begin
                        last_day_next = in_item_reg.day_of_month;
                    end
                    for (int i = 0; i < ALARM_COUNT; i++) begin
                        if (hit_any && (hit_idx == IDX_W'(i))) begin
                            fired_flags_next[i] = 1'b1;
                        end
                    end
                end
                OP_ACK: begin
                    for (int i = 0; i < ALARM_COUNT; i++) begin
                        if (in_item_reg.alarm_index == IDX_W'(i)) begin
                            fired_flags_next[i] = 1'b1;
                        end
                    end
                end
                OP_CLEAR: begin
                    fired_flags_next = '0;
                end
                default: begin
                end
            endcase
        end
        // writing an alarm disabled drops its flag
        if (cfg_we && !pwdata[EN_BIT]) begin
            for (int i = 0; i < ALARM_COUNT; i++) begin
                if (cfg_idx == REG_IDX_W'(i)) begin
                    fired_flags_next[i] = 1'b0;
                end
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            fired_flags_reg <= '0;
            last_day_reg    <= '0;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            fired_flags_reg <= fired_flags_next;
            last_day_reg    <= last_day_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                alarm_reg[i] <= ALARM_RESET[i];
            end
        end else if (cfg_we) begin
            alarm_reg[cfg_idx] <= pwdata[REG_W-1:0];
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.hour         <= s_tdata[0 +: HOUR_W];
            in_item_reg.minute       <= s_tdata[HOUR_W +: MIN_W];
            in_item_reg.weekday      <= s_tdata[HOUR_W + MIN_W +: WDAY_W];
            in_item_reg.day_of_month <= s_tdata[HOUR_W + MIN_W + WDAY_W +: DAY_W];
            in_item_reg.alarm_index  <= s_tdata[HOUR_W + MIN_W + WDAY_W + DAY_W +: IDX_W];
            in_item_reg.op           <= s_tuser;
        end
        if (advance) begin
            // only a check can fire
            fired_reg     <= (op_t'(in_item_reg.op) == OP_CHECK) && hit_any;
            fired_idx_reg <= ((op_t'(in_item_reg.op) == OP_CHECK) && hit_any) ? hit_idx : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = fired_reg;
    assign m_tdata  = {{(M_TDATA_W-IDX_W){1'b0}}, fired_idx_reg};

endmodule

FILE: rtl/wam_checker.sv
// wam_checker: port-level assertions for weekly_alarm_matcher, bound to the top
// depends on wam_pkg
`timescale 1ns / 1ps

module wam_checker #(
    parameter int ALARM_COUNT = wam_pkg::ALARM_COUNT_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wam_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import wam_pkg::*;

    // no result survives a reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a result without a firing carries index zero
    a_idle_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("non-fired result with nonzero index");

    // only configured alarms can fire, padding stays zero
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> ((32'(m_tdata[IDX_W-1:0]) < ALARM_COUNT) &&
                                   (m_tdata[M_TDATA_W-1:IDX_W] == '0)))
        else $error("fired index out of range");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind weekly_alarm_matcher wam_checker #(.ALARM_COUNT(ALARM_COUNT)) u_wam_checker (.*);

FILE: tb/sv/weekly_alarm_matcher_tb.sv
`timescale 1ns / 1ps
// weekly_alarm_matcher_tb: self-checking bench for the weekly alarm matcher,
// with a stream driver, a result monitor and an apb config writer
// depends on wam_pkg and the weekly_alarm_matcher rtl

module weekly_alarm_matcher_tb;
    import wam_pkg::*;

    // op 3 is undefined and must answer like a non-check
    localparam logic [OP_W-1:0] OP_NOOP = 2'd3;

    // alarm register indexes on the config port
    localparam int REG_ALARM_ZERO  = 0;
    localparam int REG_ALARM_ONE   = 1;
    localparam int REG_ALARM_TWO   = 2;
    localparam int REG_ALARM_THREE = 3;

    localparam alarm_word_t WORD_MAX  = 19'd392191;   // enabled, every day, 23:59
    localparam int CYCLE_LIMIT        = 200000;
    localparam int RANDOM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE    = 118;
    localparam int DRAIN_AT_ITEM      = 300;          // sender pauses here for a full drain
    localparam int HOLDOFF_CYCLES     = 150;
    localparam int SETTLE_CYCLES      = 4;            // two pipeline stages plus margin

    typedef struct packed {
        logic              fired;
        logic [IDX_W-1:0]  index;
    } alarm_hit_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // hour, minute, weekday, day_of_month, alarm_index
    logic [OP_W-1:0]       s_tuser  = '0;   // op
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // fired_index
    logic                  m_tuser;         // fired
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [ADDR_W-1:0]     paddr    = '0;
    logic [PDATA_W-1:0]    pwdata   = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    weekly_alarm_matcher dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // alarm bank model: register words, fired flags and the last known day
    // ------------------------------------------------------------------
    alarm_word_t                alarm_words [REG_COUNT] = ALARM_RESET;
    logic [ALARM_COUNT_DEF-1:0] fired_flags = '0;
    logic [DAY_W-1:0]           known_day   = '0;

    function automatic alarm_hit_t resolve_request(input req_t r);
        alarm_hit_t                hit;
        logic [DAYS_PER_WEEK-1:0]  mask;
        logic                      due;
        hit = '0;
        case (r.op)
            OP_CHECK: begin
                // a new day clears the flags, unless no day was known before
                if (r.day_of_month != 0 && r.day_of_month != known_day) begin
                    if (known_day != 0)
                        fired_flags = '0;
                    known_day = r.day_of_month;
                end
                for (int i = 0; i < ALARM_COUNT_DEF; i++) begin
                    mask = alarm_words[i][MASK_LSB +: DAYS_PER_WEEK];
                    // empty mask means daily; weekday 0 never hits a non-empty mask
                    due  = (mask == 0) || (r.weekday != 0 && mask[r.weekday - 1]);
                    if (!hit.fired && alarm_words[i][EN_BIT] && !fired_flags[i]
                        && alarm_words[i][HOUR_LSB +: HOUR_W] == r.hour
                        && alarm_words[i][MIN_LSB +: MIN_W] == r.minute && due) begin
                        fired_flags[i] = 1'b1;
                        hit.fired      = 1'b1;
                        hit.index      = IDX_W'(i);
                    end
                end
            end
            OP_ACK: begin
                fired_flags[r.alarm_index] = 1'b1;
            end
            OP_CLEAR: begin
                fired_flags = '0;
            end
            default: begin
            end
        endcase
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // shared bookkeeping
    // ------------------------------------------------------------------
    req_t       pending_requests [$];   // filled by the sequence, drained by the driver
    alarm_hit_t expected_alarms  [$];   // predicted at acceptance, popped by the monitor
    int         outstanding    = 0;     // requests queued whose result has not arrived
    int         mismatches     = 0;
    int         cycle_count    = 0;

    // ------------------------------------------------------------------
    // request driver: bursts of random length with random gaps
    // ------------------------------------------------------------------
    req_t on_bus;
    int   accepted_count = 0;
    int   burst_left     = 0;
    int   gap_left       = 0;
    logic drain_pause    = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // transaction accepted at this edge: run it through the model
            if (s_tvalid && s_tready) begin
                expected_alarms.push_back(resolve_request(on_bus));
                accepted_count++;
                if (accepted_count == DRAIN_AT_ITEM)
                    drain_pause = 1'b1;
            end
            if (drain_pause && expected_alarms.size() == 0)
                drain_pause = 1'b0;

            // a stalled transaction stays on the bus untouched
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_requests.size() != 0 && !drain_pause) begin
                    on_bus   = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_W - 21){1'b0}}, on_bus.alarm_index,
                                 on_bus.day_of_month, on_bus.weekday, on_bus.minute,
                                 on_bus.hour};
                    s_tuser  <= on_bus.op;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // mostly short bursts, now and then a long gap-free stretch
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(1, 8);
                        gap_left   = $urandom_range(1, 5);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor and receiver stall pattern
    // ------------------------------------------------------------------
    int ready_mode    = 0;
    int mode_left     = 0;
    int holdoff_left  = 0;
    int holdoffs_done = 0;
    int results_seen  = 0;

    always @(posedge aclk) begin
        alarm_hit_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_alarms.size() == 0) begin
                    $error("result with no expectation waiting: fired %0b fired_index %0d",
                           m_tuser, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_alarms.pop_front();
                    outstanding--;
                    if (m_tuser !== want.fired) begin
                        $error("fired: expected %0b, actual %0b", want.fired, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata !== {{(M_TDATA_W - IDX_W){1'b0}}, want.index}) begin
                        $error("fired_index: expected %0d, actual %0d", want.index, m_tdata);
                        mismatches++;
                    end
                end
            end

            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(40, 300);
            end else begin
                mode_left--;
            end

            // long hold-off while plenty of requests wait, so the input side backs up
            if (holdoff_left == 0 && holdoffs_done < 2 && pending_requests.size() >= 40
                && results_seen >= (holdoffs_done == 0 ? 100 : 450)) begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoffs_done++;
            end

            if (holdoff_left > 0) begin
                holdoff_left--;
                m_tready <= 1'b0;
            end else begin
                case (ready_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (mode_left % 4) != 0;
                endcase
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence helpers
    // ------------------------------------------------------------------
    function automatic alarm_word_t alarm_word(input logic en, input int mask,
                                               input int hour, input int minute);
        return {HOUR_W'(hour), MIN_W'(minute), DAYS_PER_WEEK'(mask), en};
    endfunction

    function automatic alarm_word_t random_alarm_word();
        logic en;
        int   mask;
        int   hour;
        int   minute;
        en   = ($urandom_range(0, 3) != 0);
        mask = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 127);
        // half the alarms share a few slots, so priority and flags get exercised
        if ($urandom_range(0, 1) != 0) begin
            hour   = $urandom_range(7, 8);
            minute = ($urandom_range(0, 1) != 0) ? 30 : 0;
        end else begin
            hour   = $urandom_range(0, 23);
            minute = $urandom_range(0, 59);
        end
        return alarm_word(en, mask, hour, minute);
    endfunction

    task automatic queue_request(input logic [OP_W-1:0] op, input int hour, input int minute,
                                 input int weekday, input int day, input int idx);
        req_t r;
        r.op           = op;
        r.hour         = HOUR_W'(hour);
        r.minute       = MIN_W'(minute);
        r.weekday      = WDAY_W'(weekday);
        r.day_of_month = DAY_W'(day);
        r.alarm_index  = IDX_W'(idx);
        outstanding++;
        pending_requests.push_back(r);
    endtask

    task automatic wait_for_results();
        while (outstanding != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // writes the selected registers back to back; called right after an edge
    task automatic load_alarms(input alarm_word_t words [REG_COUNT],
                               input logic [REG_COUNT-1:0] which);
        for (int i = 0; i < REG_COUNT; i++) begin
            if (which[i]) begin
                psel    <= 1'b1;
                penable <= 1'b0;
                pwrite  <= 1'b1;
                paddr   <= ADDR_W'(i * 4);
                pwdata  <= PDATA_W'(words[i]);
                @(posedge aclk);
                penable <= 1'b1;
                do @(posedge aclk); while (!pready);
                // register taken at this edge; disabling drops the fired flag
                alarm_words[i] = words[i];
                if (!words[i][EN_BIT])
                    fired_flags[i] = 1'b0;
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        alarm_word_t          words [REG_COUNT];
        logic [REG_COUNT-1:0] which;
        alarm_word_t          pick;
        int                   cur_day;
        int                   day;
        int                   roll;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset words are disabled: matching times must not fire
        queue_request(OP_CHECK, 7, 30, 1, 0, 0);
        queue_request(OP_CHECK, 10, 30, 0, 0, 3);
        wait_for_results();

        // daily, mon+sun, every day at 23:59, daily at midnight
        words[REG_ALARM_ZERO]  = alarm_word(1'b1, 0, 7, 30);
        words[REG_ALARM_ONE]   = alarm_word(1'b1, 7'b1000001, 7, 30);
        words[REG_ALARM_TWO]   = alarm_word(1'b1, 7'h7f, 23, 59);
        words[REG_ALARM_THREE] = alarm_word(1'b1, 0, 0, 0);
        load_alarms(words, 4'b1111);

        queue_request(OP_CHECK, 7, 30, 1, 5, 0);     // first known day, lowest alarm wins
        queue_request(OP_CHECK, 7, 30, 1, 5, 0);     // next one in line
        queue_request(OP_CHECK, 7, 30, 1, 5, 0);     // both spent
        queue_request(OP_CHECK, 23, 59, 0, 5, 0);    // invalid weekday vs repeat mask
        queue_request(OP_CHECK, 23, 59, 7, 0, 0);    // unknown day keeps the known one
        queue_request(OP_CHECK, 0, 0, 7, 5, 0);
        queue_request(OP_CHECK, 7, 30, 2, 6, 0);     // day change clears the flags
        queue_request(OP_CHECK, 7, 30, 2, 6, 0);     // tuesday not in the mask
        queue_request(OP_ACK, 0, 0, 0, 0, 3);
        queue_request(OP_CHECK, 0, 0, 2, 6, 0);      // acknowledged, stays quiet
        queue_request(OP_CLEAR, 0, 0, 0, 0, 0);
        queue_request(OP_CHECK, 0, 0, 2, 6, 0);
        queue_request(OP_NOOP, 7, 30, 1, 9, 2);
        queue_request(OP_CHECK, 31, 63, 7, 31, 3);   // out-of-range time, new day
        queue_request(OP_CHECK, 24, 60, 7, 31, 0);
        queue_request(OP_ACK, 31, 63, 7, 31, 0);
        queue_request(OP_CHECK, 7, 30, 7, 31, 0);    // zero acked, sunday repeat fires
        queue_request(OP_CLEAR, 31, 63, 7, 31, 3);
        queue_request(OP_CHECK, 7, 30, 7, 0, 0);
        wait_for_results();

        // zero disabled (flag drops), one at the top word, the others off
        words[REG_ALARM_ZERO]  = alarm_word(1'b0, 7'h7f, 7, 30);
        words[REG_ALARM_ONE]   = WORD_MAX;
        words[REG_ALARM_TWO]   = alarm_word(1'b0, 0, 23, 59);
        words[REG_ALARM_THREE] = '0;
        load_alarms(words, 4'b1111);

        queue_request(OP_CHECK, 23, 59, 3, 1, 0);
        queue_request(OP_ACK, 0, 0, 0, 1, 2);
        queue_request(OP_ACK, 0, 0, 0, 1, 1);
        queue_request(OP_CHECK, 23, 59, 3, 1, 0);
        queue_request(OP_CHECK, 7, 30, 3, 1, 0);
        wait_for_results();

        cur_day = 1;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            which = (phase < 3) ? 4'b1111 : REG_COUNT'($urandom_range(1, 15));
            for (int i = 0; i < REG_COUNT; i++) begin
                case (phase)
                    1:       words[i] = WORD_MAX;
                    2:       words[i] = '0;
                    3:       words[i] = (i == REG_ALARM_ZERO) ? WORD_MAX : random_alarm_word();
                    default: words[i] = random_alarm_word();
                endcase
            end
            load_alarms(words, which);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 68) begin
                    // check, usually at the time of one of the alarms
                    pick = alarm_words[$urandom_range(0, REG_COUNT - 1)];
                    roll = $urandom_range(0, 99);
                    if (roll < 8)
                        cur_day = $urandom_range(1, 31);
                    day = (roll >= 8 && roll < 14) ? 0 : cur_day;
                    if ($urandom_range(0, 3) != 0)
                        queue_request(OP_CHECK, pick[HOUR_LSB +: HOUR_W],
                                      pick[MIN_LSB +: MIN_W], $urandom_range(0, 7), day,
                                      $urandom_range(0, 3));
                    else
                        queue_request(OP_CHECK, $urandom_range(0, 31), $urandom_range(0, 63),
                                      $urandom_range(0, 7), day, $urandom_range(0, 3));
                end else begin
                    queue_request((roll < 84) ? OP_ACK : (roll < 96) ? OP_CLEAR : OP_NOOP,
                                  $urandom_range(0, 31), $urandom_range(0, 63),
                                  $urandom_range(0, 7), $urandom_range(0, 31),
                                  $urandom_range(0, 3));
                end
            end
            wait_for_results();
        end

        if (expected_alarms.size() != 0) begin
            $error("%0d expected results never arrived", expected_alarms.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/wam_pkg.sv
rtl/weekly_alarm_matcher.sv
rtl/wam_checker.sv
tb/sv/weekly_alarm_matcher_tb.sv
